// ===== rtl/npcs_pkg.sv =====
// Shared types, constants and microcode program of the nearest palette colour search.
`default_nettype none
package npcs_pkg;

   localparam int ENTRIES_DEFAULT = 256;
   localparam int COLOUR_W        = 8;
   localparam int INDEX_W         = 8;
   localparam int SQUARE_W        = 2 * COLOUR_W;
   localparam int BEST_W          = 20;
   localparam logic [BEST_W-1:0] SEARCH_START = 20'd999999;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [INDEX_W-1:0]  entry_index;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } npcs_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic               exact_hit;
   } npcs_rsp_type;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_INIT,
      STEP_SCAN,
      STEP_DRAIN1,
      STEP_DRAIN2,
      STEP_RESULT
   } step_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_QUERY,
      COND_NOT_LAST,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     addr_clear;
      logic     issue;
      logic     best_init;
      logic     rsp_load;
      cond_type cond;
      step_type jump;
      step_type next;
   } ctrl_word_type;

   // Microcode ROM: one control word per step.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = '{req_ready: 1'b0, addr_clear: 1'b0, issue: 1'b0, best_init: 1'b0,
             rsp_load: 1'b0, cond: COND_NONE, jump: STEP_IDLE, next: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            cw.req_ready = 1'b1;
            cw.cond      = COND_QUERY;
            cw.jump      = STEP_INIT;
            cw.next      = STEP_IDLE;
         end
         STEP_INIT: begin
            cw.addr_clear = 1'b1;
            cw.best_init  = 1'b1;
            cw.next       = STEP_SCAN;
         end
         STEP_SCAN: begin
            cw.issue = 1'b1;
            cw.cond  = COND_NOT_LAST;
            cw.jump  = STEP_SCAN;
            cw.next  = STEP_DRAIN1;
         end
         STEP_DRAIN1: begin
            cw.next = STEP_DRAIN2;
         end
         STEP_DRAIN2: begin
            cw.next = STEP_RESULT;
         end
         STEP_RESULT: begin
            cw.rsp_load = 1'b1;
            cw.cond     = COND_RSP_FREE;
            cw.jump     = STEP_IDLE;
            cw.next     = STEP_RESULT;
         end
         default: begin
            cw.next = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/npcs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/nearest_palette_colour_search.sv =====
// Top level of the nearest palette colour search: sequencer, palette RAM and distance datapath.
`default_nettype none
// Holds a palette of ENTRIES RGB entries, greyscale after reset (entry a holds a,a,a).
// A write transaction (req_type 0) stores one entry and returns nothing; writes to an
// index at or above ENTRIES are dropped. A query transaction (req_type 1) returns the
// lowest index with the smallest squared RGB distance, plus exact_hit when that distance
// is zero. A query scans the palette RAM one entry per cycle; its steps from acceptance
// until the sequencer is back in idle are one set-up step, ENTRIES read steps, two steps
// to drain the three-stage distance pipe, and one step to load the result register.
// Only idle takes a new transaction, so a query must finish before the next is taken;
// the single read port of the palette RAM sets this limit. The result register lets the
// next transaction be taken while a result waits; a second result finding the register
// still full parks the sequencer in its result step, and the input stalls until the
// waiting result is taken.
// No clearing pass: per-entry valid bits stand in for the greyscale reset contents.
module nearest_palette_colour_search #(
   parameter int ENTRIES = npcs_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire npcs_pkg::npcs_req_type req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output npcs_pkg::npcs_rsp_type     rsp_payload
);

   import npcs_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_ADDR = IW'(ENTRIES - 1);
   localparam logic [INDEX_W:0] ENTRIES_LIMIT = (INDEX_W + 1)'(ENTRIES);

   // ---------------- sequencer ----------------
   step_type      step_ff, step_in;
   ctrl_word_type cw;
   logic          cond_true;

   logic req_fire, is_query, is_write, rsp_free, rsp_load;
   logic [IW-1:0] addr_ff, addr_in;

   always_comb begin
      cw = ucode_rom(step_ff);
   end

   assign req_ready = cw.req_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_query  = req_fire && (req_payload.req_type == REQ_QUERY);
   assign is_write  = req_fire && (req_payload.req_type == REQ_WRITE) &&
                      ({1'b0, req_payload.entry_index} < ENTRIES_LIMIT);
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign rsp_load  = cw.rsp_load && rsp_free;

   always_comb begin
      case (cw.cond)
         COND_QUERY:    cond_true = is_query;
         COND_NOT_LAST: cond_true = (addr_ff != LAST_ADDR);
         COND_RSP_FREE: cond_true = rsp_free;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in = cond_true ? cw.jump : cw.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // read address counter
   always_comb begin
      addr_in = addr_ff;
      if (cw.addr_clear) begin
         addr_in = '0;
      end else if (cw.issue) begin
         addr_in = addr_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   // ---------------- palette store ----------------
   logic [ENTRIES-1:0]        entry_valid_ff;
   logic [3*COLOUR_W-1:0]     ram_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (is_write) begin
         entry_valid_ff[req_payload.entry_index[IW-1:0]] <= 1'b1;
      end
   end

   npcs_ram #(
      .WIDTH (3 * COLOUR_W),
      .DEPTH (ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (is_write),
      .wr_addr (req_payload.entry_index[IW-1:0]),
      .wr_data ({req_payload.red, req_payload.green, req_payload.blue}),
      .rd_en   (cw.issue),
      .rd_addr (addr_ff),
      .rd_data (ram_q)
   );

   // query colour, held for the whole scan
   logic [COLOUR_W-1:0] q_red_ff, q_green_ff, q_blue_ff;

   always_ff @(posedge clock) begin
      if (is_query) begin
         q_red_ff   <= req_payload.red;
         q_green_ff <= req_payload.green;
         q_blue_ff  <= req_payload.blue;
      end
   end

   // ---------------- distance pipe ----------------
   // stage 1: RAM data out, valid bit and index alongside
   logic          s1_vld_ff, s1_written_ff;
   logic [IW-1:0] s1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cw.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.issue) begin
         s1_idx_ff     <= addr_ff;
         s1_written_ff <= entry_valid_ff[addr_ff];
      end
   end

   // an entry never written reads as its greyscale reset value
   logic [COLOUR_W-1:0] e_red, e_green, e_blue, grey;
   assign grey = COLOUR_W'(s1_idx_ff);
   assign e_red   = s1_written_ff ? ram_q[3*COLOUR_W-1:2*COLOUR_W] : grey;
   assign e_green = s1_written_ff ? ram_q[2*COLOUR_W-1:COLOUR_W]   : grey;
   assign e_blue  = s1_written_ff ? ram_q[COLOUR_W-1:0]            : grey;

   function automatic logic [SQUARE_W-1:0] sq_diff(input logic [COLOUR_W-1:0] a,
                                                   input logic [COLOUR_W-1:0] b);
      logic [COLOUR_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQUARE_W'(d) * SQUARE_W'(d);
   endfunction

   // stage 2: per-component squares
   logic                s2_vld_ff;
   logic [IW-1:0]       s2_idx_ff;
   logic [SQUARE_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         s2_idx_ff <= s1_idx_ff;
         sq_r_ff   <= sq_diff(q_red_ff, e_red);
         sq_g_ff   <= sq_diff(q_green_ff, e_green);
         sq_b_ff   <= sq_diff(q_blue_ff, e_blue);
      end
   end

   // stage 3: sum and running minimum; strict less-than keeps the lowest index on ties
   logic [BEST_W-1:0] cand_dist, best_ff, best_in;
   logic [IW-1:0]     best_at_ff, best_at_in;

   assign cand_dist = BEST_W'(sq_r_ff) + BEST_W'(sq_g_ff) + BEST_W'(sq_b_ff);

   always_comb begin
      best_in    = best_ff;
      best_at_in = best_at_ff;
      if (cw.best_init) begin
         best_in    = SEARCH_START;
         best_at_in = '0;
      end else if (s2_vld_ff && (cand_dist < best_ff)) begin
         best_in    = cand_dist;
         best_at_in = s2_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff    <= best_in;
      best_at_ff <= best_at_in;
   end

   // ---------------- result register ----------------
   logic         rsp_valid_ff, rsp_valid_in;
   npcs_rsp_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.best_index <= INDEX_W'(best_at_ff);
         rsp_ff.exact_hit  <= (best_ff == '0);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- assertions ----------------
   // new transactions only while the distance pipe is empty
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("transaction taken while scan pipe busy");

   // result step sees a drained pipe and a minimum below the start value
   a_result_ready: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_RESULT) |-> (!s1_vld_ff && !s2_vld_ff && (best_ff < SEARCH_START)))
      else $error("result step reached before scan completed");

   // every scan covers entry zero through the last entry
   a_scan_wraps: assert property (@(posedge clock) disable iff (reset)
      ((step_ff == STEP_SCAN) && (step_in == STEP_DRAIN1)) |-> (addr_ff == LAST_ADDR))
      else $error("scan ended early");

endmodule
`default_nettype wire

// ===== tb/palette_search_checker.sv =====
// Checker for the nearest palette colour search: palette shadow, match prediction and compare.
`timescale 1ns / 1ps
module palette_search_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire npcs_pkg::npcs_req_type req_payload,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire npcs_pkg::npcs_rsp_type rsp_payload,
   output int                          mismatch_count,
   output int                          awaited_count,
   output int                          query_count,
   output int                          write_count,
   output int                          exact_count
);
   import npcs_pkg::*;

   localparam int PALETTE_SIZE = ENTRIES_DEFAULT;

   logic [COLOUR_W-1:0] pal_red   [PALETTE_SIZE];
   logic [COLOUR_W-1:0] pal_green [PALETTE_SIZE];
   logic [COLOUR_W-1:0] pal_blue  [PALETTE_SIZE];

   npcs_rsp_type awaited_matches [$];

   // Lowest index at the smallest squared RGB distance from the query colour.
   function automatic npcs_rsp_type nearest_entry(input npcs_req_type query);
      npcs_rsp_type      match;
      logic [BEST_W-1:0] best_dist;
      logic [BEST_W-1:0] sq_dist;
      int                dr;
      int                dg;
      int                db;
      best_dist = SEARCH_START;
      match     = '0;
      for (int e = 0; e < PALETTE_SIZE; e++) begin
         dr      = int'(query.red)   - int'(pal_red[e]);
         dg      = int'(query.green) - int'(pal_green[e]);
         db      = int'(query.blue)  - int'(pal_blue[e]);
         sq_dist = BEST_W'(dr * dr + dg * dg + db * db);
         if (sq_dist < best_dist) begin
            best_dist        = sq_dist;
            match.best_index = INDEX_W'(e);
         end
      end
      match.exact_hit = (best_dist == '0);
      return match;
   endfunction

   always @(posedge clock) begin : watch
      npcs_rsp_type want;
      int           errs;
      errs = 0;
      if (reset) begin
         for (int e = 0; e < PALETTE_SIZE; e++) begin
            pal_red[e]   = COLOUR_W'(e);
            pal_green[e] = COLOUR_W'(e);
            pal_blue[e]  = COLOUR_W'(e);
         end
         awaited_matches.delete();
         mismatch_count <= 0;
         awaited_count  <= 0;
         query_count    <= 0;
         write_count    <= 0;
         exact_count    <= 0;
      end else begin
         // results first: one leaving now belongs to an earlier query
         if (rsp_valid && rsp_ready) begin
            if (awaited_matches.size() == 0) begin
               $display("%0t: result with none awaited: index %0d exact %0b",
                        $time, rsp_payload.best_index, rsp_payload.exact_hit);
               errs++;
            end else begin
               want = awaited_matches.pop_front();
               if (rsp_payload.best_index !== want.best_index) begin
                  $display("%0t: best_index expected %0d actual %0d",
                           $time, want.best_index, rsp_payload.best_index);
                  errs++;
               end
               if (rsp_payload.exact_hit !== want.exact_hit) begin
                  $display("%0t: exact_hit expected %0b actual %0b",
                           $time, want.exact_hit, rsp_payload.exact_hit);
                  errs++;
               end
               if (want.exact_hit)
                  exact_count <= exact_count + 1;
            end
         end
         if (req_valid && req_ready) begin
            if (req_payload.req_type == REQ_WRITE) begin
               if (int'(req_payload.entry_index) < PALETTE_SIZE) begin
                  pal_red[req_payload.entry_index]   = req_payload.red;
                  pal_green[req_payload.entry_index] = req_payload.green;
                  pal_blue[req_payload.entry_index]  = req_payload.blue;
               end
               write_count <= write_count + 1;
            end else begin
               awaited_matches.push_back(nearest_entry(req_payload));
               query_count <= query_count + 1;
            end
         end
         mismatch_count <= mismatch_count + errs;
         awaited_count  <= awaited_matches.size();
      end
   end

endmodule

// ===== tb/tb_nearest_palette_colour_search.sv =====
// Testbench top for the nearest palette colour search: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_nearest_palette_colour_search;
   import npcs_pkg::*;

   localparam int PALETTE_SIZE  = ENTRIES_DEFAULT;
   // a query keeps the sequencer busy for a full scan plus set-up and drain
   localparam int SCAN_CYCLES   = PALETTE_SIZE + 5;
   localparam int SETTLE_CYCLES = SCAN_CYCLES + 40;
   // long enough for two queries to finish and park, so the input stalls
   localparam int HOLD_CYCLES   = 3 * SCAN_CYCLES;
   localparam int RANDOM_ITEMS  = 120;
   localparam int CALM_ITEMS    = 30;
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   npcs_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   npcs_rsp_type rsp_payload;

   int mismatch_count;
   int awaited_count;
   int query_count;
   int write_count;
   int exact_count;
   int cycle_count;

   // stimulus-side copy of the palette, only used to aim queries at live entries
   logic [COLOUR_W-1:0] aim_red   [PALETTE_SIZE];
   logic [COLOUR_W-1:0] aim_green [PALETTE_SIZE];
   logic [COLOUR_W-1:0] aim_blue  [PALETTE_SIZE];

   logic calm;      // no idling on either side
   logic back2back; // sender offers transactions with no gaps
   logic hold_now;  // set by the stimulus, cleared by the receiver once the hold is over

   nearest_palette_colour_search #(
      .ENTRIES(PALETTE_SIZE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   palette_search_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .mismatch_count(mismatch_count),
      .awaited_count (awaited_count),
      .query_count   (query_count),
      .write_count   (write_count),
      .exact_count   (exact_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still awaited",
                     $time, cycle_count, awaited_count);
            $display("tb_nearest_palette_colour_search NOT OK");
            $finish;
         end
      end
   end

   // Result receiver: random stalls in bursts, one long hold-off on request,
   // and always ready once the run goes calm.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_now) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_now = 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic npcs_req_type make_item(input logic kind,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [COLOUR_W-1:0] r,
                                              input logic [COLOUR_W-1:0] g,
                                              input logic [COLOUR_W-1:0] b);
      npcs_req_type item;
      item.req_type    = kind;
      item.entry_index = idx;
      item.red         = r;
      item.green       = g;
      item.blue        = b;
      return item;
   endfunction

   // Mostly uniform, with the component extremes turning up often.
   function automatic logic [COLOUR_W-1:0] pick_colour();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return COLOUR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Query component a small step away from an entry's, clamped to range.
   function automatic logic [COLOUR_W-1:0] nudge(input logic [COLOUR_W-1:0] c);
      int v;
      v = int'(c) + $urandom_range(0, 8) - 4;
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return COLOUR_W'(v);
   endfunction

   // Idle burst between transactions; payload carries junk while valid is low.
   task automatic sender_gap();
      if (!calm && !back2back && $urandom_range(0, 3) == 0) begin
         req_valid   <= 1'b0;
         req_payload <= make_item(1'($urandom_range(0, 1)), pick_colour(), pick_colour(),
                                  pick_colour(), pick_colour());
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Offer one transaction and hold it until the block takes it. Valid is left
   // high so a following transaction can go out on the very next edge.
   task automatic offer(input npcs_req_type item);
      sender_gap();
      req_valid   <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic write_entry(input logic [INDEX_W-1:0] idx,
                              input logic [COLOUR_W-1:0] r,
                              input logic [COLOUR_W-1:0] g,
                              input logic [COLOUR_W-1:0] b);
      aim_red[idx]   = r;
      aim_green[idx] = g;
      aim_blue[idx]  = b;
      offer(make_item(REQ_WRITE, idx, r, g, b));
   endtask

   // entry_index is random on queries: the block must not look at it
   task automatic query_colour(input logic [COLOUR_W-1:0] r,
                               input logic [COLOUR_W-1:0] g,
                               input logic [COLOUR_W-1:0] b);
      offer(make_item(REQ_QUERY, INDEX_W'($urandom_range(0, 255)), r, g, b));
   endtask

   // Stop offering until every awaited result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (awaited_count != 0);
   endtask

   initial begin : stimulus
      int pick;
      int kind;
      for (int e = 0; e < PALETTE_SIZE; e++) begin
         aim_red[e]   = COLOUR_W'(e);
         aim_green[e] = COLOUR_W'(e);
         aim_blue[e]  = COLOUR_W'(e);
      end
      calm        = 1'b0;
      back2back   = 1'b0;
      hold_now    = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: greyscale palette after reset ---
      query_colour(8'd0, 8'd0, 8'd0);          // black hits entry 0 exactly
      query_colour(8'd255, 8'd255, 8'd255);    // white hits entry 255 exactly
      query_colour(8'd10, 8'd20, 8'd30);       // off the grey axis, no exact hit
      query_colour(8'd128, 8'd127, 8'd129);

      // --- ties: equal distance goes to the lower index ---
      write_entry(8'd3, 8'd255, 8'd0, 8'd0);
      write_entry(8'd7, 8'd255, 8'd0, 8'd2);
      query_colour(8'd255, 8'd0, 8'd1);        // 3 and 7 both at distance 1
      write_entry(8'd200, 8'd255, 8'd0, 8'd0); // duplicate of entry 3
      query_colour(8'd255, 8'd0, 8'd0);        // exact tie, entry 3 wins

      // --- index extremes ---
      write_entry(8'd255, 8'd0, 8'd0, 8'd0);
      query_colour(8'd0, 8'd0, 8'd0);          // entries 0 and 255 both black
      write_entry(8'd0, 8'd0, 8'd0, 8'd1);
      query_colour(8'd0, 8'd0, 8'd0);          // now only the last entry matches
      write_entry(8'd128, 8'd0, 8'd255, 8'd0);
      write_entry(8'd64, 8'd0, 8'd0, 8'd255);
      query_colour(8'd0, 8'd255, 8'd0);
      query_colour(8'd0, 8'd0, 8'd255);
      query_colour(8'd1, 8'd254, 8'd3);
      write_entry(8'd1, 8'd170, 8'd85, 8'd170);
      query_colour(8'd170, 8'd85, 8'd170);
      query_colour(8'd85, 8'd170, 8'd85);

      // sender pause: nothing offered until every result is back
      drain_results();

      // --- flood the palette with black, then ask for the far corner:
      // largest possible distance, and every entry tied ---
      for (int e = 0; e < PALETTE_SIZE; e++)
         write_entry(INDEX_W'(e), 8'd0, 8'd0, 8'd0);
      query_colour(8'd255, 8'd255, 8'd255);
      query_colour(8'd0, 8'd0, 8'd0);

      // --- random part: writes colour the palette as it goes ---
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;

         // receiver holds off while queries keep coming: the result register
         // fills, the sequencer parks and the input stalls
         if (i == 40) begin
            hold_now  = 1'b1;
            back2back = 1'b1;
            repeat (4)
               query_colour(pick_colour(), pick_colour(), pick_colour());
            back2back = 1'b0;
         end

         if (i == 80)
            drain_results();

         if ($urandom_range(0, 1) == 0) begin
            write_entry(INDEX_W'($urandom_range(0, 255)), pick_colour(), pick_colour(),
                        pick_colour());
         end else begin
            pick = $urandom_range(0, PALETTE_SIZE - 1);
            kind = $urandom_range(0, 9);
            if (kind < 4)
               query_colour(aim_red[pick], aim_green[pick], aim_blue[pick]);
            else if (kind < 7)
               query_colour(nudge(aim_red[pick]), nudge(aim_green[pick]),
                            nudge(aim_blue[pick]));
            else
               query_colour(pick_colour(), pick_colour(), pick_colour());
         end
      end

      // all offered: wait for the last results, then let the block settle
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d queries (%0d exact hits) and %0d palette writes,",
               query_count, exact_count, write_count);
      $display("including ties, a full-palette flood and an input stall under back-pressure.");
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("tb_nearest_palette_colour_search OK");
      end else begin
         $display("%0d mismatches, %0d results never seen", mismatch_count, awaited_count);
         $display("tb_nearest_palette_colour_search NOT OK");
      end
      $finish;
   end

endmodule
